### src/spqm_pkg.sv
package spqm_pkg;

  localparam int unsigned SpqCapacity    = 16;
  localparam int unsigned SpqPayloadBits = 32;
  localparam int unsigned PrioW          = 8;
  localparam int unsigned DataW          = 32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_SEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CMP_EQ = 3'd0,
    CMP_NE = 3'd1,
    CMP_LE = 3'd2,
    CMP_GE = 3'd3,
    CMP_LT = 3'd4,
    CMP_GT = 3'd5
  } cmp_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ROW_HOLD   = 2'd0,
    ROW_INSERT = 2'd1,
    ROW_ROTATE = 2'd2,
    ROW_DROP   = 2'd3
  } row_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  typedef struct packed {
    row_op_e row_op;
    cnt_op_e cnt_op;
    logic    load;
  } dp_cmd_t;

  typedef struct packed {
    logic head_match;
    logic full;
    logic empty;
  } dp_stat_t;

  function automatic logic prio_match(input logic [PrioW-1:0] p,
                                      input logic [PrioW-1:0] lim,
                                      input logic [2:0]       op);
    logic m;
    case (op)
      CMP_EQ:  m = (p == lim);
      CMP_NE:  m = (p != lim);
      CMP_LE:  m = (p <= lim);
      CMP_GE:  m = (p >= lim);
      CMP_LT:  m = (p < lim);
      CMP_GT:  m = (p > lim);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

### src/spqm_datapath.sv
module spqm_datapath #(
  parameter int unsigned CAPACITY     = spqm_pkg::SpqCapacity,
  parameter int unsigned PAYLOAD_BITS = spqm_pkg::SpqPayloadBits,
  parameter int unsigned CntW         = $clog2(CAPACITY + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spqm_pkg::dp_cmd_t              cmd_i,
  input  logic [spqm_pkg::PrioW-1:0]     prio_i,
  input  logic [2:0]                     op_i,
  input  logic [spqm_pkg::DataW-1:0]     data_i,
  output spqm_pkg::dp_stat_t             stat_o,
  output logic [PAYLOAD_BITS-1:0]        head_pay_o,
  output logic [CntW-1:0]                count_o
);
  import spqm_pkg::*;

  logic [PrioW-1:0]        prio_q [CAPACITY];
  logic [PrioW-1:0]        prio_d [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_q  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_d  [CAPACITY];
  logic [CAPACITY-1:0]     ins;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [PrioW-1:0]        req_prio_q;
  logic [2:0]              req_op_q;
  logic [63:0]             din_wide;
  logic [PAYLOAD_BITS-1:0] new_pay;

  assign din_wide = 64'(data_i);
  assign new_pay  = din_wide[PAYLOAD_BITS-1:0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [PrioW-1:0]        prev_p, next_p;
    logic [PAYLOAD_BITS-1:0] prev_d, next_d;
    logic                    prev_ins;
    logic                    is_last;

    // Insertion point and everything behind it: entries with a greater priority
    // plus the free slots.
    assign ins[g] = ((CntW'(g) < cnt_q) && (prio_q[g] > prio_i)) || (CntW'(g) >= cnt_q);
    assign is_last = (CntW'(g + 1) == cnt_q);

    if (g == 0) begin : g_first
      assign prev_p   = prio_q[g];
      assign prev_d   = pay_q[g];
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign prev_p   = prio_q[g-1];
      assign prev_d   = pay_q[g-1];
      assign prev_ins = ins[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_p = prio_q[g];
      assign next_d = pay_q[g];
    end else begin : g_body
      assign next_p = prio_q[g+1];
      assign next_d = pay_q[g+1];
    end

    always_comb begin
      prio_d[g] = prio_q[g];
      pay_d[g]  = pay_q[g];
      case (cmd_i.row_op)
        ROW_INSERT: begin
          if (ins[g] && prev_ins) begin
            prio_d[g] = prev_p;
            pay_d[g]  = prev_d;
          end else if (ins[g]) begin
            prio_d[g] = prio_i;
            pay_d[g]  = new_pay;
          end
        end
        ROW_ROTATE: begin
          // wrap the head around to the last occupied slot
          if (is_last) begin
            prio_d[g] = prio_q[0];
            pay_d[g]  = pay_q[0];
          end else begin
            prio_d[g] = next_p;
            pay_d[g]  = next_d;
          end
        end
        ROW_DROP: begin
          prio_d[g] = next_p;
          pay_d[g]  = next_d;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      prio_q[i] <= prio_d[i];
      pay_q[i]  <= pay_d[i];
    end
    if (cmd_i.load) begin
      req_prio_q <= prio_i;
      req_op_q   <= op_i;
    end
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CntW'(1);
      CNT_DEC: cnt_d = cnt_q - CntW'(1);
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign stat_o.head_match = prio_match(prio_q[0], req_prio_q, req_op_q);
  assign stat_o.full       = (cnt_q == CntW'(CAPACITY));
  assign stat_o.empty      = (cnt_q == '0);
  assign head_pay_o        = pay_q[0];
  assign count_o           = cnt_q;

endmodule

### src/spqm_ctrl.sv
module spqm_ctrl #(
  parameter int unsigned PAYLOAD_BITS = spqm_pkg::SpqPayloadBits,
  parameter int unsigned CntW         = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [spqm_pkg::DataW-1:0] data_o,
  output spqm_pkg::dp_cmd_t          dp_cmd_o,
  input  spqm_pkg::dp_stat_t         dp_stat_i,
  input  logic [PAYLOAD_BITS-1:0]    head_pay_i,
  input  logic [CntW-1:0]            count_i
);
  import spqm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e             state_q;
  logic               valid_q;
  status_e            status_q;
  logic [DataW-1:0]   data_q;
  logic [CntW-1:0]    steps_q;
  logic               found_q;
  logic               pop_q;
  logic               accept;
  logic               hit;
  logic [63:0]        head_wide;

  assign in_ready_o  = (state_q == ST_IDLE) && (!valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign hit         = !found_q && dp_stat_i.head_match;
  assign head_wide   = 64'(head_pay_i);
  assign out_valid_o = valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;

  always_comb begin
    dp_cmd_o.row_op = ROW_HOLD;
    dp_cmd_o.cnt_op = CNT_HOLD;
    dp_cmd_o.load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dp_cmd_o.load = 1'b1;
          case (cmd_e'(cmd_i))
            CMD_PUSH: begin
              if (!dp_stat_i.full) begin
                dp_cmd_o.row_op = ROW_INSERT;
                dp_cmd_o.cnt_op = CNT_INC;
              end
            end
            CMD_CLEAR: dp_cmd_o.cnt_op = CNT_CLR;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // on a pop, take the first match out of the row; otherwise keep rotating to restore order
        if (hit && pop_q) begin
          dp_cmd_o.row_op = ROW_DROP;
          dp_cmd_o.cnt_op = CNT_DEC;
        end else begin
          dp_cmd_o.row_op = ROW_ROTATE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= 1'b0;
      status_q <= STAT_OK;
      data_q   <= '0;
      steps_q  <= '0;
      found_q  <= 1'b0;
      pop_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            data_q <= '0;
            case (cmd_e'(cmd_i))
              CMD_PUSH: begin
                valid_q  <= 1'b1;
                status_q <= dp_stat_i.full ? STAT_FULL : STAT_OK;
              end
              CMD_CLEAR: begin
                valid_q  <= 1'b1;
                status_q <= STAT_OK;
              end
              default: begin
                if (dp_stat_i.empty) begin
                  valid_q  <= 1'b1;
                  status_q <= STAT_MISS;
                end else begin
                  valid_q <= 1'b0;
                  state_q <= ST_SCAN;
                  steps_q <= count_i;
                  found_q <= 1'b0;
                  pop_q   <= (cmd_e'(cmd_i) == CMD_POP);
                end
              end
            endcase
          end else if (valid_q && out_ready_i) begin
            valid_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            found_q <= 1'b1;
            data_q  <= head_wide[DataW-1:0];
          end
          steps_q <= steps_q - CntW'(1);
          if (steps_q == CntW'(1)) begin
            state_q  <= ST_IDLE;
            valid_q  <= 1'b1;
            status_q <= (found_q || hit) ? STAT_OK : STAT_MISS;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/sorted_priority_queue_match.sv
// Channel   Dir  Fields (low bit first)
// s_axis    in   tuser: cmd[1:0]; tdata: priority_req[7:0], compare_op[10:8], data_in[42:11]
// m_axis    out  tuser: status[1:0]; tdata: data_out[31:0], count[32 +: CntW]
//
// Push, clear, and pop or seek on an empty store: result in the cycle after acceptance.
// Pop and seek: the entry row rotates one slot a cycle past the single head comparator,
// so a scan brings every stored entry to the head in turn.
// One item in flight; the next is taken in the cycle its predecessor's result leaves.
// Reset empties the store at once; entry contents need no clearing.
// A stalled result holds in the output register until m_axis_tready.
module sorted_priority_queue_match #(
  parameter int unsigned CAPACITY     = spqm_pkg::SpqCapacity,
  parameter int unsigned PAYLOAD_BITS = spqm_pkg::SpqPayloadBits,
  localparam int unsigned CntW        = $clog2(CAPACITY + 1),
  localparam int unsigned OutW        = ((spqm_pkg::DataW + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [47:0]     s_axis_tdata,  // priority_req, compare_op, data_in
  input  logic [1:0]      s_axis_tuser,  // cmd
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,  // data_out, count
  output logic [1:0]      m_axis_tuser   // status
);
  import spqm_pkg::*;

  dp_cmd_t                 dp_cmd;
  dp_stat_t                dp_stat;
  logic [PAYLOAD_BITS-1:0] head_pay;
  logic [CntW-1:0]         count;
  logic [DataW-1:0]        data_out;

  spqm_ctrl #(
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .CntW        (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_o   (m_axis_tuser),
    .data_o     (data_out),
    .dp_cmd_o   (dp_cmd),
    .dp_stat_i  (dp_stat),
    .head_pay_i (head_pay),
    .count_i    (count)
  );

  spqm_datapath #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .CntW        (CntW)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (dp_cmd),
    .prio_i    (s_axis_tdata[7:0]),
    .op_i      (s_axis_tdata[10:8]),
    .data_i    (s_axis_tdata[42:11]),
    .stat_o    (dp_stat),
    .head_pay_o(head_pay),
    .count_o   (count)
  );

  assign m_axis_tdata = OutW'({count, data_out});

endmodule

### src/spqm_checker.sv
module spqm_sva #(
  parameter int unsigned CAPACITY = spqm_pkg::SpqCapacity,
  localparam int unsigned CntW    = $clog2(CAPACITY + 1),
  localparam int unsigned OutW    = ((spqm_pkg::DataW + CntW + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic [1:0]      m_axis_tuser
);
  import spqm_pkg::*;

  logic [CntW-1:0]  count;
  logic [DataW-1:0] data_out;

  assign count    = m_axis_tdata[DataW +: CntW];
  assign data_out = m_axis_tdata[DataW-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count <= CntW'(CAPACITY)))
    else $error("result count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STAT_FULL)) |-> (count == CntW'(CAPACITY)))
    else $error("full status with room left");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != STAT_OK)) |-> (data_out == '0))
    else $error("payload on a failed transaction");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_MISS ||
                       m_axis_tuser == STAT_FULL))
    else $error("unknown status code");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue_match spqm_sva #(.CAPACITY(CAPACITY)) u_spqm_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

### tb/spqm_checker.sv
module spqm_checker #(
  parameter int unsigned CntW = $clog2(spqm_pkg::SpqCapacity + 1),
  parameter int unsigned OutW = ((spqm_pkg::DataW + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  input  logic            s_tready_i,
  input  logic [47:0]     s_tdata_i,
  input  logic [1:0]      s_tuser_i,
  input  logic            m_tvalid_i,
  input  logic            m_tready_i,
  input  logic [OutW-1:0] m_tdata_i,
  input  logic [1:0]      m_tuser_i,
  output int unsigned     errors_o,
  output int unsigned     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import spqm_pkg::*;

  typedef struct {
    logic [PrioW-1:0] prio;
    logic [DataW-1:0] payload;
  } entry_t;

  typedef struct {
    logic [1:0]       status;
    logic [DataW-1:0] data;
    logic [CntW-1:0]  count;
  } result_t;

  // Model of the store, slot 0 at the lowest-priority end
  entry_t      held_entries[$];
  result_t     expected_results[$];
  int unsigned error_cnt = 0;

  function automatic logic prio_satisfies(input logic [PrioW-1:0] p,
                                          input logic [PrioW-1:0] ref_prio,
                                          input logic [2:0]       op);
    case (op)
      CMP_EQ:  return p == ref_prio;
      CMP_NE:  return p != ref_prio;
      CMP_LE:  return p <= ref_prio;
      CMP_GE:  return p >= ref_prio;
      CMP_LT:  return p < ref_prio;
      CMP_GT:  return p > ref_prio;
      default: return 1'b0;
    endcase
  endfunction

  // Apply one command to the model store and return the result it produces
  function automatic result_t apply_command(input cmd_e             cmd,
                                            input logic [PrioW-1:0] prio,
                                            input logic [2:0]       op,
                                            input logic [DataW-1:0] data);
    result_t res;
    entry_t  item;
    int      pos;
    res.status = STAT_OK;
    res.data   = '0;
    case (cmd)
      CMD_PUSH: begin
        if (held_entries.size() >= SpqCapacity) begin
          res.status = STAT_FULL;
        end else begin
          // equal priorities keep arrival order: insert after the last one not greater
          pos = held_entries.size();
          while (pos > 0 && held_entries[pos-1].prio > prio) pos--;
          item.prio    = prio;
          item.payload = data;
          held_entries.insert(pos, item);
        end
      end
      CMD_POP, CMD_SEEK: begin
        pos = -1;
        foreach (held_entries[i]) begin
          if (pos < 0 && prio_satisfies(held_entries[i].prio, prio, op)) pos = i;
        end
        if (pos < 0) begin
          res.status = STAT_MISS;
        end else begin
          res.data = held_entries[pos].payload;
          if (cmd == CMD_POP) held_entries.delete(pos);
        end
      end
      default: begin
        held_entries.delete();
      end
    endcase
    res.count = CntW'(held_entries.size());
    return res;
  endfunction

  always @(posedge clk_i) begin
    result_t          want;
    logic [DataW-1:0] got_data;
    logic [CntW-1:0]  got_count;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got_data  = m_tdata_i[DataW-1:0];
        got_count = m_tdata_i[DataW +: CntW];
        if (expected_results.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("%0t: result transaction with nothing expected: status %0d data %h count %0d",
                     $realtime, m_tuser_i, got_data, got_count);
        end else begin
          want = expected_results.pop_front();
          if (m_tuser_i !== want.status || got_data !== want.data ||
              got_count !== want.count) begin
            error_cnt++;
            if (error_cnt <= 10)
              $display("%0t: mismatch: status %0d/%0d data %h/%h count %0d/%0d (exp/act)",
                       $realtime, want.status, m_tuser_i, want.data, got_data,
                       want.count, got_count);
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_results.push_back(apply_command(cmd_e'(s_tuser_i), s_tdata_i[7:0],
                                                 s_tdata_i[10:8], s_tdata_i[42:11]));
    end
    errors_o  <= error_cnt;
    pending_o <= expected_results.size();
  end

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spqm_pkg::*;

  localparam int unsigned CntW       = $clog2(SpqCapacity + 1);
  localparam int unsigned OutW       = ((DataW + CntW + 7) / 8) * 8;
  localparam int unsigned NumRandom  = 1280;
  localparam int unsigned TailItems  = 150;
  localparam int unsigned CycleLimit = 400000;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [47:0]     s_axis_tdata;  // priority_req[7:0], compare_op[10:8], data_in[42:11]
  logic [1:0]      s_axis_tuser;  // cmd
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;  // data_out[31:0], count[36:32]
  logic [1:0]      m_axis_tuser;  // status

  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  bit          idle_en   = 1'b1;

  sorted_priority_queue_match u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  spqm_checker #(
    .CntW (CntW),
    .OutW (OutW)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stall bursts while idling is enabled
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // Present one command and hold it until the transaction completes
  task automatic send_command(input cmd_e             cmd,
                              input logic [PrioW-1:0] prio,
                              input logic [2:0]       op,
                              input logic [DataW-1:0] data);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'b0, data, op, prio};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    int unsigned      mode;
    int unsigned      push_pct;
    int unsigned      roll;
    cmd_e             cmd;
    logic [PrioW-1:0] prio;
    logic [2:0]       op;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PUSH;
    mode          = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // take-out from an empty store
    send_command(CMD_POP,  8'd0, CMP_EQ, 32'h0);
    send_command(CMD_SEEK, 8'd0, CMP_GE, 32'h0);
    // extremes of priority and payload, then a run of equal priorities
    send_command(CMD_PUSH, 8'd255, CMP_EQ, 32'hFFFF_FFFF);
    send_command(CMD_PUSH, 8'd0,   CMP_EQ, 32'h0000_0000);
    send_command(CMD_PUSH, 8'd128, CMP_EQ, 32'hA5A5_0001);
    send_command(CMD_PUSH, 8'd128, CMP_EQ, 32'h5A5A_0002);
    send_command(CMD_PUSH, 8'd128, CMP_EQ, 32'hC3C3_0003);
    // every comparison, including the undefined codes
    send_command(CMD_SEEK, 8'd128, CMP_EQ, 32'h0);
    send_command(CMD_SEEK, 8'd0,   CMP_NE, 32'h0);
    send_command(CMD_SEEK, 8'd128, CMP_LE, 32'h0);
    send_command(CMD_SEEK, 8'd129, CMP_GE, 32'h0);
    send_command(CMD_SEEK, 8'd0,   CMP_LT, 32'h0);
    send_command(CMD_SEEK, 8'd254, CMP_GT, 32'h0);
    send_command(CMD_SEEK, 8'd128, 3'd6,   32'h0);
    send_command(CMD_POP,  8'd128, 3'd7,   32'h0);
    send_command(CMD_POP,  8'd128, CMP_EQ, 32'h0);
    send_command(CMD_POP,  8'd128, CMP_GT, 32'h0);
    send_command(CMD_POP,  8'd128, CMP_LT, 32'h0);
    send_command(CMD_POP,  8'd5,   CMP_NE, 32'h0);
    send_command(CMD_CLEAR, 8'd0,  CMP_EQ, 32'h0);
    send_command(CMD_POP,  8'd0,   CMP_GE, 32'h0);
    send_command(CMD_PUSH, 8'd7,   CMP_EQ, 32'h55AA_55AA);
    send_command(CMD_POP,  8'd255, CMP_LE, 32'h0);

    for (int unsigned i = 0; i < NumRandom; i++) begin
      // phases that fill, drain or churn the store
      if (i % 50 == 0) mode = $urandom_range(0, 2);
      if (i >= NumRandom - TailItems) idle_en = 1'b0;
      else if (i % 100 == 0) idle_en = ($urandom_range(0, 3) != 0);
      push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 2) cmd = CMD_CLEAR;
      else if (roll < push_pct) cmd = CMD_PUSH;
      else if ($urandom_range(0, 1) == 0) cmd = CMD_POP;
      else cmd = CMD_SEEK;
      // a narrow priority pool makes ties and hits common
      roll = $urandom_range(0, 9);
      if (roll == 0) prio = 8'd0;
      else if (roll == 1) prio = 8'd255;
      else if (roll < 7) prio = 8'(100 + $urandom_range(0, 7));
      else prio = 8'($urandom());
      if ($urandom_range(0, 9) > 7) op = 3'($urandom_range(6, 7));
      else op = 3'($urandom_range(0, 5));
      send_command(cmd, prio, op, $urandom());
    end
    s_axis_tvalid <= 1'b0;

    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
